/* rtl/mhpq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared widths, defaults and codes of the min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int KEY_W            = 32;
   localparam int FILL_W           = 9;
   localparam int STATUS_W         = 2;
   localparam int DEF_CAPACITY     = 256;
   localparam int DEF_TAG_WIDTH    = 9;

   // Operation codes carried in the request tuser bit.
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage : mhpq_pkg
`default_nettype wire

/* rtl/min_heap_priority_queue_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_priority_queue_top
// Binary min-heap of key and tag pairs held in one on-chip memory.
//
//   Channel   Direction   Handshake             Contents
//   req_      in          tvalid/tready         tuser: opcode; tdata: key, tag
//   rsp_      out         tvalid/tready         tuser: status; tdata: key, tag, fill
//
// One item at a time. A push lets the new entry climb level by level, a pop
// reads the root and the last entry and lets the moved entry sink level by
// level, at most about log2(CAPACITY) levels. At each level the read of the
// next level overlaps the write-back of the current one on the memory.
// Reset is synchronous and active high; it empties the heap at once and needs
// no clearing pass. A new item is accepted while a finished result still
// waits in the output register; the block stalls only if a second result is
// ready before the first one is taken.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_top
   import mhpq_pkg::*;
#(
   parameter int CAPACITY  = DEF_CAPACITY,
   parameter int TAG_WIDTH = DEF_TAG_WIDTH,
   localparam int REQ_DATA_W = ((KEY_W + TAG_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((KEY_W + TAG_WIDTH + FILL_W + 7) / 8) * 8
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire                     req_tuser,   // opcode
   input  wire  [REQ_DATA_W-1:0]   req_tdata,   // key_in, tag_in
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [STATUS_W-1:0]     rsp_tuser,   // status
   output logic [RSP_DATA_W-1:0]   rsp_tdata    // key_out, tag_out, fill_count
);

   localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW      = $clog2(CAPACITY + 1);
   localparam int IDX_W   = AW + 2;
   localparam int ENTRY_W = KEY_W + TAG_WIDTH;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_PUSH_UP = 3'd1;
   localparam logic [2:0] S_POP_RD  = 3'd2;
   localparam logic [2:0] S_POP_DN  = 3'd3;
   localparam logic [2:0] S_PLACE   = 3'd4;
   localparam logic [2:0] S_FINISH  = 3'd5;

   // Heap storage, entry = {tag, key}.
   logic [ENTRY_W-1:0] heap_mem [CAPACITY];

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [ENTRY_W-1:0]  moving_ff, moving_in;
   logic [KEY_W-1:0]    res_key_ff, res_key_in;
   logic [TAG_WIDTH-1:0] res_tag_ff, res_tag_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [KEY_W-1:0]    rsp_key_ff;
   logic [TAG_WIDTH-1:0] rsp_tag_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [FILL_W-1:0]   rsp_fill_ff;
   logic                rsp_load;

   logic [ENTRY_W-1:0]  rd_a_data_ff, rd_b_data_ff;
   logic [AW-1:0]       rd_a_addr, rd_b_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [ENTRY_W-1:0]  wr_data;

   logic                accept;
   logic [KEY_W-1:0]    in_key;
   logic [TAG_WIDTH-1:0] in_tag;
   logic [IDX_W-1:0]    n_ext, left_idx, right_idx, pick_idx, next_left;
   logic                right_ok;
   logic [ENTRY_W-1:0]  pick_entry;
   logic [AW-1:0]       up_idx;

   assign accept = req_tvalid && req_tready;
   assign in_key = req_tdata[KEY_W-1:0];
   assign in_tag = req_tdata[KEY_W +: TAG_WIDTH];

   // Sift-down child selection: the right child wins only if strictly smaller.
   assign n_ext      = IDX_W'(count_ff);
   assign left_idx   = (IDX_W'(pos_ff) << 1) + IDX_W'(1);
   assign right_idx  = left_idx + IDX_W'(1);
   assign right_ok   = (right_idx < n_ext) &&
                       (rd_b_data_ff[KEY_W-1:0] < rd_a_data_ff[KEY_W-1:0]);
   assign pick_idx   = right_ok ? right_idx : left_idx;
   assign pick_entry = right_ok ? rd_b_data_ff : rd_a_data_ff;
   assign next_left  = (pick_idx << 1) + IDX_W'(1);
   assign up_idx     = (pos_ff - AW'(1)) >> 1;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      moving_in     = moving_ff;
      res_key_in    = res_key_ff;
      res_tag_in    = res_tag_ff;
      res_status_in = res_status_ff;
      rd_a_addr     = '0;
      rd_b_addr     = '0;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = moving_ff;
      rsp_load      = 1'b0;
      req_tready    = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_key_in    = '0;
               res_tag_in    = '0;
               res_status_in = ST_OK;
               if (req_tuser == OP_PUSH) begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     res_status_in = ST_FULL;
                     state_in      = S_FINISH;
                  end else begin
                     moving_in = {in_tag, in_key};
                     pos_in    = AW'(count_ff);
                     count_in  = count_ff + CW'(1);
                     rd_a_addr = AW'((count_ff - CW'(1)) >> 1);
                     state_in  = (count_ff == '0) ? S_PLACE : S_PUSH_UP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                     state_in      = S_FINISH;
                  end else begin
                     pos_in    = '0;
                     count_in  = count_ff - CW'(1);
                     rd_a_addr = '0;
                     rd_b_addr = AW'(count_ff - CW'(1));
                     state_in  = S_POP_RD;
                  end
               end
            end
         end
         S_PUSH_UP: begin
            wr_en = 1'b1;
            if (rd_a_data_ff[KEY_W-1:0] > moving_ff[KEY_W-1:0]) begin
               // Parent moves down into the hole; the hole climbs one level.
               wr_data   = rd_a_data_ff;
               pos_in    = up_idx;
               rd_a_addr = (up_idx - AW'(1)) >> 1;
               state_in  = (up_idx == '0) ? S_PLACE : S_PUSH_UP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_POP_RD: begin
            res_key_in = rd_a_data_ff[KEY_W-1:0];
            res_tag_in = rd_a_data_ff[KEY_W +: TAG_WIDTH];
            moving_in  = rd_b_data_ff;
            rd_a_addr  = AW'(left_idx);
            rd_b_addr  = AW'(right_idx);
            state_in   = (left_idx >= n_ext) ? S_PLACE : S_POP_DN;
         end
         S_POP_DN: begin
            wr_en = 1'b1;
            if (moving_ff[KEY_W-1:0] <= pick_entry[KEY_W-1:0]) begin
               state_in = S_FINISH;
            end else begin
               // Smaller child moves up; the hole sinks one level.
               wr_data   = pick_entry;
               pos_in    = AW'(pick_idx);
               rd_a_addr = AW'(next_left);
               rd_b_addr = AW'(next_left + IDX_W'(1));
               state_in  = (next_left >= n_ext) ? S_PLACE : S_POP_DN;
            end
         end
         S_PLACE: begin
            wr_en    = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      moving_ff     <= moving_in;
      res_key_ff    <= res_key_in;
      res_tag_ff    <= res_tag_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_key_ff    <= res_key_ff;
         rsp_tag_ff    <= res_tag_ff;
         rsp_status_ff <= res_status_ff;
         rsp_fill_ff   <= FILL_W'(count_ff);
      end
   end

   // Heap memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_data_ff <= heap_mem[rd_a_addr];
      rd_b_data_ff <= heap_mem[rd_b_addr];
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_fill_ff, rsp_tag_ff, rsp_key_ff});

endmodule : min_heap_priority_queue_top
`default_nettype wire

/* sim/min_heap_priority_queue_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue_top_tb
// Self-checking bench for the min-heap priority queue. Push and pop items go
// in on the request stream, in random bursts. Every accepted item runs through
// a behavioral heap kept in the bench. The response stream stalls on its own
// pattern, and every response is checked in order against that heap's output.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_top_tb;
   import mhpq_pkg::*;

   localparam int HEAP_CAP = DEF_CAPACITY;
   localparam int TAG_W    = DEF_TAG_WIDTH;
   localparam int REQ_W    = ((KEY_W + TAG_W + 7) / 8) * 8;
   localparam int RSP_W    = ((KEY_W + TAG_W + FILL_W + 7) / 8) * 8;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [TAG_W-1:0]    tag;
      logic [STATUS_W-1:0] status;
      logic [FILL_W-1:0]   fill;
   } heap_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic                req_tuser = OP_PUSH;          // opcode
   logic [REQ_W-1:0]    req_tdata = '0;               // key_in, tag_in
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [STATUS_W-1:0] rsp_tuser;                    // status
   logic [RSP_W-1:0]    rsp_tdata;                    // key_out, tag_out, fill_count

   // Behavioral copy of the heap, advanced once per accepted item.
   logic [KEY_W-1:0]    heap_key [HEAP_CAP];
   logic [TAG_W-1:0]    heap_tag [HEAP_CAP];
   int                  heap_fill = 0;

   heap_result_type     results_due [$];
   int                  error_count = 0;
   int                  results_seen = 0;
   int                  push_count = 0;
   int                  pop_count = 0;
   int                  full_refusals = 0;
   int                  empty_refusals = 0;
   int                  deepest_fill = 0;
   int                  burst_left = 0;
   bit                  rsp_hold_request = 1'b0;

   min_heap_priority_queue_top #(
      .CAPACITY  (HEAP_CAP),
      .TAG_WIDTH (TAG_W)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic heap_result_type apply_heap_op(input logic op,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [TAG_W-1:0] tag);
      heap_result_type r;
      int pos;
      int up;
      int child;
      logic [KEY_W-1:0] swap_key;
      logic [TAG_W-1:0] swap_tag;
      r = '0;
      r.status = ST_OK;
      if (op == OP_PUSH) begin
         push_count++;
         if (heap_fill >= HEAP_CAP) begin
            r.status = ST_FULL;
            full_refusals++;
         end else begin
            pos = heap_fill;
            heap_fill++;
            // Parents move down only while strictly greater than the new key.
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (heap_key[up] <= key) break;
               heap_key[pos] = heap_key[up];
               heap_tag[pos] = heap_tag[up];
               pos = up;
            end
            heap_key[pos] = key;
            heap_tag[pos] = tag;
         end
      end else begin
         pop_count++;
         if (heap_fill == 0) begin
            r.status = ST_EMPTY;
            empty_refusals++;
         end else begin
            r.key = heap_key[0];
            r.tag = heap_tag[0];
            heap_fill--;
            heap_key[0] = heap_key[heap_fill];
            heap_tag[0] = heap_tag[heap_fill];
            pos = 0;
            // The right child wins only on a strictly smaller key.
            while (2 * pos + 1 < heap_fill) begin
               child = 2 * pos + 1;
               if (child + 1 < heap_fill && heap_key[child + 1] < heap_key[child])
                  child++;
               if (heap_key[pos] <= heap_key[child]) break;
               swap_key = heap_key[pos];
               swap_tag = heap_tag[pos];
               heap_key[pos] = heap_key[child];
               heap_tag[pos] = heap_tag[child];
               heap_key[child] = swap_key;
               heap_tag[child] = swap_tag;
               pos = child;
            end
         end
      end
      if (heap_fill > deepest_fill) deepest_fill = heap_fill;
      r.fill = FILL_W'(heap_fill);
      return r;
   endfunction

   // Keys lean toward the extremes and a narrow band, so that ties are common.
   function automatic logic [KEY_W-1:0] pick_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      if (sel <= 4) return KEY_W'($urandom_range(0, 31));
      return KEY_W'($urandom);
   endfunction

   // Called at a rising edge; returns at the edge that accepts the item.
   task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                            input logic [TAG_W-1:0] tag);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         req_tuser  <= 1'($urandom);
         req_tdata  <= REQ_W'({$urandom, $urandom});
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_W - KEY_W - TAG_W){1'b0}}, tag, key};
      do @(posedge clock); while (!req_tready);
      results_due.push_back(apply_heap_op(op, key, tag));
      burst_left--;
   endtask

   task automatic test_empty_and_extremes();
      send_item(OP_POP, '1, '1);
      send_item(OP_POP, '0, '0);
      send_item(OP_PUSH, '1, 9'h1FF);
      send_item(OP_PUSH, '0, 9'h000);
      send_item(OP_PUSH, 32'h8000_0000, 9'h155);
      send_item(OP_PUSH, '1, 9'h0AA);
      send_item(OP_PUSH, 32'h0000_0001, 9'h100);
      repeat (6) send_item(OP_POP, KEY_W'($urandom), TAG_W'($urandom));
   endtask

   task automatic test_equal_keys();
      for (int i = 1; i <= 5; i++) send_item(OP_PUSH, 32'd5, TAG_W'(i * 97));
      repeat (5) send_item(OP_POP, '0, '0);
   endtask

   task automatic test_fill_to_capacity();
      while (heap_fill < HEAP_CAP) send_item(OP_PUSH, pick_key(), TAG_W'($urandom));
      repeat (2) send_item(OP_PUSH, pick_key(), TAG_W'($urandom));
      while (heap_fill > 0) send_item(OP_POP, KEY_W'($urandom), TAG_W'($urandom));
      send_item(OP_POP, '0, '0);
   endtask

   task automatic test_output_backpressure();
      rsp_hold_request = 1'b1;
      for (int i = 0; i < 12; i++)
         send_item((i < 8) ? OP_PUSH : OP_POP, pick_key(), TAG_W'($urandom));
   endtask

   // Phases of different push bias walk the fill level between empty and full.
   task automatic test_random_traffic(input int n_items);
      int sent;
      int phase_left;
      int push_pct;
      sent = 0;
      phase_left = 0;
      push_pct = 50;
      while (sent < n_items) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(50, 400);
            push_pct = 10 + 20 * $urandom_range(0, 4);
         end
         send_item(($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_POP,
                   pick_key(), TAG_W'($urandom));
         phase_left--;
         sent++;
      end
   endtask

   // Response side: changing stall modes, and a long hold-off on request.
   initial begin : rsp_stall
      int cyc;
      int mode;
      int hold_left;
      cyc = 0;
      mode = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 2) == 0);
               default: rsp_tready <= (cyc % 8 != 0);
            endcase
            cyc++;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      heap_result_type want;
      heap_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.key    = rsp_tdata[KEY_W-1:0];
         got.tag    = rsp_tdata[KEY_W +: TAG_W];
         got.fill   = rsp_tdata[KEY_W + TAG_W +: FILL_W];
         got.status = rsp_tuser;
         results_seen++;
         if (results_due.size() == 0) begin
            $display("%0t: unexpected response item key %h tag %h status %0d fill %0d",
                     $time, got.key, got.tag, got.status, got.fill);
            error_count++;
         end else begin
            want = results_due.pop_front();
            if (got.key !== want.key) begin
               $display("%0t: key mismatch, expected %h actual %h",
                        $time, want.key, got.key);
               error_count++;
            end
            if (got.tag !== want.tag) begin
               $display("%0t: tag mismatch, expected %h actual %h",
                        $time, want.tag, got.tag);
               error_count++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d actual %0d",
                        $time, want.status, got.status);
               error_count++;
            end
            if (got.fill !== want.fill) begin
               $display("%0t: fill count mismatch, expected %0d actual %0d",
                        $time, want.fill, got.fill);
               error_count++;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("Run timed out with %0d responses outstanding.", results_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : main_sequence
      int drain_cycles;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_extremes();
      test_equal_keys();
      test_fill_to_capacity();
      test_output_backpressure();
      test_random_traffic(1400);
      req_tvalid <= 1'b0;
      drain_cycles = 0;
      while (results_due.size() != 0 && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (results_due.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, results_due.size());
         error_count++;
      end
      repeat (40) @(posedge clock);
      $display("Checked %0d responses from %0d pushes and %0d pops; deepest fill %0d.",
               results_seen, push_count, pop_count, deepest_fill);
      $display("Refused %0d pushes on a full heap and %0d pops on an empty one.",
               full_refusals, empty_refusals);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/mhpq_pkg.sv
rtl/min_heap_priority_queue_top.sv
sim/min_heap_priority_queue_top_tb.sv
